// ----- hdl/codon_adaptation_index_macros.svh -----
// assertion macros shared by the codon adaptation index rtl
// no dependencies; take in by `include inside a module body
`ifndef CODON_ADAPTATION_INDEX_MACROS_SVH
`define CODON_ADAPTATION_INDEX_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CAI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cai_pkg.sv -----
// shared types and constants of the codon adaptation index block
// no dependencies; used by cai_div and codon_adaptation_index
`timescale 1ns / 1ps

package cai_pkg;

	// default parameter values
	localparam int CAI_MAX_LEN       = 65536;
	localparam int CAI_LOG_FRAC_BITS = 12;
	localparam int CAI_OUT_FRAC_BITS = 15;

	// codon table
	localparam int ROM_DEPTH = 64;
	localparam int CODON_W   = 6;
	localparam int unsigned MAG_SCALE = 10000000;

	// -ln(weight) in units of 1e-7, indexed by the three 2-bit base codes
	localparam logic [31:0] LOG_MAG [ROM_DEPTH] = '{
		32'd2744368,  32'd5798185,  32'd14271164, 32'd8209806,
		32'd19661129, 32'd8209806,  32'd14696760, 32'd16607312,
		32'd35065579, 32'd13470736, 32'd35065579, 32'd19661129,
		32'd24079456, 32'd8675006,  32'd0,        32'd7133499,
		32'd10498221, 32'd5447272,  32'd4307829,  32'd8675006,
		32'd16607312, 32'd21202635, 32'd6733446,  32'd17147984,
		32'd28134107, 32'd9162907,  32'd23025851, 32'd9675840,
		32'd32188758, 32'd23025851, 32'd6931472,  32'd22072749,
		32'd3710637,  32'd9675840,  32'd11711830, 32'd4780358,
		32'd15606477, 32'd13093333, 32'd10788097, 32'd17147984,
		32'd20402208, 32'd9942523,  32'd18971200, 32'd10498221,
		32'd18325815, 32'd14696760, 32'd15141277, 32'd9416085,
		32'd4462871,  32'd5621189,  32'd24079456, 32'd8439701,
		32'd20402208, 32'd18971200, 32'd18971200, 32'd17719568,
		32'd13093333, 32'd5798185,  32'd0,        32'd8209806,
		32'd21202635, 32'd5447272,  32'd20402208, 32'd8675006
	};

	// e^-1 in unsigned q.32
	localparam logic [31:0] INV_E_Q32 = 32'd1580030169;

	// exp series length cap and shortest useful sequence
	localparam int KMAX    = 40;
	localparam int MIN_LEN = 3;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_SHORT = 2'd1;
	localparam status_t STAT_NONE  = 2'd2;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- hdl/cai_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on cai_pkg (div_stat_t) and codon_adaptation_index_macros.svh
`timescale 1ns / 1ps

module cai_div #(
	parameter int W  = 32,
	parameter int DW = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [DW-1:0]     divisor,
	output logic [W-1:0]      quotient,
	output cai_pkg::div_stat_t stat
);
	import cai_pkg::*;
	`include "codon_adaptation_index_macros.svh"

	localparam int CW = $clog2(W + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	div_stat_t     stat_q;
	logic [DW+1:0] trial;
	logic          fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {1'b0, rem_q, quo_q[W-1]} - {2'b00, dvs_q};
	assign fits  = !trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			stat_q.busy <= 1'b1;
			stat_q.done <= 1'b0;
			cnt_q       <= CW'(W);
		end else if (stat_q.busy) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				stat_q.busy <= 1'b0;
				stat_q.done <= 1'b1;
			end
		end else begin
			stat_q.done <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (stat_q.busy) begin
			rem_q <= fits ? trial[DW-1:0] : {rem_q[DW-2:0], quo_q[W-1]};
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat     = stat_q;

	`CAI_ASSERT_NOW(a_start_idle, clk, arst_n, start, !stat_q.busy, "divider started while busy")
	`CAI_ASSERT_NEXT(a_start_busy, clk, arst_n, start, stat_q.busy && !stat_q.done, "divider did not start")
	`CAI_ASSERT_NOW(a_done_idle, clk, arst_n, stat_q.done, !stat_q.busy, "divider done while busy")

endmodule

// ----- hdl/codon_adaptation_index.sv -----
// codon adaptation index: streaming codon scorer with divide and exp finish
// depends on cai_pkg, cai_div and codon_adaptation_index_macros.svh
`timescale 1ns / 1ps

// Takes one nucleotide byte per item on the sym channel and gives one result
// item on the res channel for each item that carries last. While a sequence
// streams in, an item is taken every cycle. After the last item the block
// stalls the sym channel for the finish: a state of checks, then, when
// there is a valid codon, mean = sum / count on a restoring divider of
// DIV_W = max(accumulator width, 32) bits, an e^-f series of up to about
// 13 terms at default widths, each a multiply plus a divide on the same
// divider, up to three e^-1 multiply and round steps, and a closing power
// step and the load of the output register. Short and codon-less sequences
// go from the checks straight to the output load. A finished result waits
// in the output register; the next sequence streams in while it waits, and
// its own finish holds until that register is free. Bytes past MAX_LEN are
// dropped silently, lowercase or unknown bytes void their frame, U counts
// as T, and a trailing partial frame is ignored.
module codon_adaptation_index #(
	parameter int MAX_LEN       = cai_pkg::CAI_MAX_LEN,
	parameter int LOG_FRAC_BITS = cai_pkg::CAI_LOG_FRAC_BITS,
	parameter int OUT_FRAC_BITS = cai_pkg::CAI_OUT_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        sym_valid,
	output logic        sym_stall,
	input  logic [7:0]  symbol,
	input  logic        last,
	// result item channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] cai_value,
	output logic [14:0] valid_codons,
	output logic [1:0]  status
);
	import cai_pkg::*;
	`include "codon_adaptation_index_macros.svh"

	// widths that follow from the parameters
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int TALLY_W = $clog2(MAX_LEN / 3 + 1);
	localparam int QW      = LOG_FRAC_BITS + 2;      // rom magnitude stays below 4.0
	localparam int ACC_W   = QW + TALLY_W;
	localparam int NW      = QW - LOG_FRAC_BITS;      // integer part of the mean
	localparam int DIV_W   = (ACC_W > 32) ? ACC_W : 32;
	localparam int DIV_DW  = (TALLY_W > 6) ? TALLY_W : 6;
	localparam int KW      = $clog2(KMAX + 1);

	// ascii codes
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_U = 8'h55;

	// sequencer states
	localparam logic [3:0] S_ACC   = 4'd0;  // streaming bytes
	localparam logic [3:0] S_FIN   = 4'd1;  // classify the sequence
	localparam logic [3:0] S_MEAN  = 4'd2;  // wait for sum / count
	localparam logic [3:0] S_MUL   = 4'd3;  // term * f
	localparam logic [3:0] S_TDIV  = 4'd4;  // start term / k
	localparam logic [3:0] S_TWAIT = 4'd5;  // wait for term / k
	localparam logic [3:0] S_POW   = 4'd6;  // v * e^-1
	localparam logic [3:0] S_PRND  = 4'd7;  // round the product back
	localparam logic [3:0] S_OUT   = 4'd8;  // load the result item

	localparam logic [32:0] V_ONE = 33'h1_0000_0000;

	// log weight magnitudes rounded to LOG_FRAC_BITS, worked out at elaboration
	logic [QW-1:0] rom_tbl [ROM_DEPTH];
	for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
		localparam logic [63:0] QV = ((64'(LOG_MAG[gi]) << LOG_FRAC_BITS)
			+ 64'(MAG_SCALE / 2)) / 64'(MAG_SCALE);
		assign rom_tbl[gi] = QV[QW-1:0];
	end

	// base decode: {bad, code}, a before c before g before t
	function automatic logic [2:0] nuc_decode(logic [7:0] s);
		logic [2:0] r;
		unique case (s) inside
			CH_A:       r = 3'b000;
			CH_C:       r = 3'b001;
			CH_G:       r = 3'b010;
			CH_T, CH_U: r = 3'b011;
			default:    r = 3'b100;
		endcase
		return r;
	endfunction

	logic [3:0]         state_q;
	logic [3:0]         frame_codes_q;
	logic               frame_bad_q;
	logic [1:0]         phase_q;
	logic [LEN_W-1:0]   total_q;
	logic [ACC_W-1:0]   acc_q;
	logic [TALLY_W-1:0] tally_q;

	// finish datapath
	status_t            status_q;
	logic [32:0]        v_q;       // running e^-t, q.32
	logic [31:0]        term_q;    // current series term, q.32
	logic [31:0]        f_q;       // fractional part of t, q.32
	logic [KW-1:0]      k_q;
	logic [NW-1:0]      n_q;
	logic [64:0]        prod_q;

	// output register
	logic               res_valid_q;
	logic [15:0]        cai_value_q;
	logic [14:0]        valid_codons_q;
	status_t            status_out_q;

	logic [2:0]         dec;
	logic [CODON_W-1:0] codon_idx;
	logic               seq_ok;
	logic               res_take;
	logic               out_free;

	// shared multiplier
	logic [32:0]        mul_a;
	logic [31:0]        mul_b;
	logic [64:0]        mul_p;
	logic [64:0]        rnd_sum;

	// shared divider
	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_DW-1:0]  div_divisor;
	logic [DIV_W-1:0]   div_quo;
	div_stat_t          div_stat;

	logic [QW-1:0]      mean_t;
	logic [31:0]        mean_f;
	logic [31:0]        term_d;
	logic [33:0]        out_rnd;
	logic [33:0]        out_val;
	logic [31:0]        tally_ext;

	assign dec       = nuc_decode(symbol);
	assign codon_idx = {frame_codes_q, dec[1:0]};
	assign sym_stall = (state_q != S_ACC);
	assign res_take  = res_valid_q && !res_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign seq_ok    = (total_q >= LEN_W'(MIN_LEN)) && (tally_q != '0);

	// term * f during the series, v * e^-1 during the power steps
	assign mul_a   = (state_q == S_MUL) ? {1'b0, term_q} : v_q;
	assign mul_b   = (state_q == S_MUL) ? f_q : INV_E_Q32;
	assign mul_p   = 65'(mul_a) * 65'(mul_b);
	assign rnd_sum = prod_q + (65'(1) << 31);

	// sum / count once, then term / k for each series term
	assign div_start    = ((state_q == S_FIN) && seq_ok) || (state_q == S_TDIV);
	assign div_dividend = (state_q == S_FIN) ? DIV_W'(acc_q) : DIV_W'(prod_q[63:32]);
	assign div_divisor  = (state_q == S_FIN) ? DIV_DW'(tally_q) : DIV_DW'(k_q);

	cai_div #(
		.W  (DIV_W),
		.DW (DIV_DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// t = floor(sum / count) splits into integer n and fraction f
	assign mean_t = div_quo[QW-1:0];
	assign mean_f = {mean_t[LOG_FRAC_BITS-1:0], {(32 - LOG_FRAC_BITS){1'b0}}};
	assign term_d = div_quo[31:0];

	// round q.32 to OUT_FRAC_BITS, saturate to the port
	assign out_rnd   = {1'b0, v_q} + (34'(1) << (31 - OUT_FRAC_BITS));
	assign out_val   = out_rnd >> (32 - OUT_FRAC_BITS);
	assign tally_ext = 32'(tally_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_ACC;
			frame_codes_q <= '0;
			frame_bad_q   <= 1'b0;
			phase_q       <= '0;
			total_q       <= '0;
			acc_q         <= '0;
			tally_q       <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			// a take while the next result loads is handled in the load
			if (res_take && state_q != S_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ACC: begin
					if (sym_valid) begin
						// bytes past the length cap are dropped
						if (total_q < LEN_W'(MAX_LEN)) begin
							total_q <= total_q + LEN_W'(1);
							unique case (phase_q)
								2'd0: begin
									frame_bad_q   <= dec[2];
									frame_codes_q <= {dec[1:0], 2'b00};
									phase_q       <= 2'd1;
								end
								2'd1: begin
									frame_bad_q   <= frame_bad_q || dec[2];
									frame_codes_q <= {frame_codes_q[3:2], dec[1:0]};
									phase_q       <= 2'd2;
								end
								default: begin
									if (!frame_bad_q && !dec[2]) begin
										acc_q   <= acc_q + ACC_W'(rom_tbl[codon_idx]);
										tally_q <= tally_q + TALLY_W'(1);
									end
									phase_q <= 2'd0;
								end
							endcase
						end
						if (last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (total_q < LEN_W'(MIN_LEN)) begin
						state_q <= S_OUT;
					end else if (tally_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_stat.done) begin
						// n never exceeds 3 with this table, so no underflow cut
						if (mean_f == '0) begin
							state_q <= S_POW;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					state_q <= S_TWAIT;
				end
				S_TWAIT: begin
					if (div_stat.done) begin
						if (term_d == '0 || k_q == KW'(KMAX)) begin
							state_q <= S_POW;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_POW: begin
					if (n_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_PRND;
					end
				end
				S_PRND: begin
					state_q <= S_POW;
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						// clear for the next sequence
						frame_codes_q <= '0;
						frame_bad_q   <= 1'b0;
						phase_q       <= '0;
						total_q       <= '0;
						acc_q         <= '0;
						tally_q       <= '0;
						state_q       <= S_ACC;
					end
				end
				default: begin
					state_q <= S_ACC;
				end
			endcase
		end
	end

	// finish datapath and output payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_FIN: begin
				if (total_q < LEN_W'(MIN_LEN)) begin
					status_q <= STAT_SHORT;
				end else if (tally_q == '0) begin
					status_q <= STAT_NONE;
				end else begin
					status_q <= STAT_OK;
				end
			end
			S_MEAN: begin
				if (div_stat.done) begin
					n_q    <= mean_t[QW-1:LOG_FRAC_BITS];
					f_q    <= mean_f;
					term_q <= mean_f;
					k_q    <= KW'(2);
					v_q    <= V_ONE - {1'b0, mean_f};
				end
			end
			S_MUL: begin
				prod_q <= mul_p;
			end
			S_TWAIT: begin
				if (div_stat.done && term_d != '0) begin
					// odd terms subtract, even terms add
					if (k_q[0]) begin
						v_q <= v_q - {1'b0, term_d};
					end else begin
						v_q <= v_q + {1'b0, term_d};
					end
					term_q <= term_d;
					k_q    <= k_q + KW'(1);
				end
			end
			S_POW: begin
				if (n_q != '0) begin
					prod_q <= mul_p;
				end
			end
			S_PRND: begin
				v_q <= rnd_sum[64:32];
				n_q <= n_q - NW'(1);
			end
			S_OUT: begin
				if (out_free) begin
					status_out_q <= status_q;
					if (status_q != STAT_OK) begin
						cai_value_q <= '0;
					end else if (|out_val[33:16]) begin
						cai_value_q <= 16'hFFFF;
					end else begin
						cai_value_q <= out_val[15:0];
					end
					valid_codons_q <= (tally_ext > 32'h7FFF) ? 15'h7FFF : tally_ext[14:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid    = res_valid_q;
	assign cai_value    = cai_value_q;
	assign valid_codons = valid_codons_q;
	assign status       = status_out_q;

	`CAI_ASSERT_NOW(a_ok_has_codons, clk, arst_n, res_valid && status == STAT_OK, valid_codons != '0, "ok result without codons")
	`CAI_ASSERT_NOW(a_fail_zero, clk, arst_n, res_valid && status != STAT_OK, cai_value == '0, "failed result with nonzero value")
	`CAI_ASSERT_NOW(a_len_cap, clk, arst_n, 1'b1, total_q <= LEN_W'(MAX_LEN) && phase_q != 2'd3, "length or frame phase out of range")

endmodule
